>>> rtl/core/sacksb_pkg.sv
package sacksb_pkg;

   // Table geometry.
   localparam int MAX_REGIONS = 64;
   localparam int IDX_W = $clog2(MAX_REGIONS);
   localparam int CNT_W = $clog2(MAX_REGIONS + 1);
   localparam int SEQ_W = 32;
   localparam int LIMIT_W = 8;
   localparam logic [LIMIT_W-1:0] SACK_LIMIT_RESET = 8'd3;

   // Command codes of the input word.
   typedef enum logic [3:0] {
      OP_INIT,
      OP_DISCARD,
      OP_ENQUEUE,
      OP_SET_SACKED,
      OP_CHECK,
      OP_HI_SACKED,
      OP_HI_RESENT,
      OP_RUN,
      OP_SACKED_TOTAL,
      OP_SACKED_FROM,
      OP_SACK_COUNT,
      OP_CLR_SACKED,
      OP_CLR_RESENT
   } opcode_type;

   // Status codes of the result word.
   typedef enum logic [1:0] {
      ST_OK,
      ST_FULL,
      ST_RANGE
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_PROC,
      S_EMIT,
      S_TAIL,
      S_APPEND
   } state_type;

   // One region of sent sequence space.
   typedef struct packed {
      logic [SEQ_W-1:0] seq_lo;
      logic [SEQ_W-1:0] seq_hi;
      logic             sacked;
      logic             resent;
   } region_type;

   localparam int ENTRY_W = $bits(region_type);

   // Memory requests from the sequencer to the two table banks.
   typedef struct packed {
      logic             we;
      logic             wbank;
      logic [IDX_W-1:0] waddr;
      region_type       wdata;
      logic             rbank;
      logic [IDX_W-1:0] raddr;
   } mem_req_type;

   // Region splitter request and answer.
   typedef struct packed {
      opcode_type       op;
      region_type       seg;
      logic [SEQ_W-1:0] win_lo;
      logic [SEQ_W-1:0] cut_a;
      logic [SEQ_W-1:0] cut_b;
      logic [SEQ_W-1:0] off_a;
      logic [SEQ_W-1:0] off_b;
   } cut_req_type;

   typedef struct packed {
      region_type piece;
      logic       keep;
      logic       done;
   } cut_rsp_type;

endpackage

>>> rtl/core/sacksb_ram.sv
module sacksb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/sacksb_cut.sv
module sacksb_cut (
   input  sacksb_pkg::cut_req_type req,
   output sacksb_pkg::cut_rsp_type rsp
);
   import sacksb_pkg::*;

   logic [SEQ_W-1:0] off_lo;
   logic [SEQ_W-1:0] off_hi;
   logic [SEQ_W-1:0] off_end;
   logic             splits;
   logic             a_in;
   logic             b_in;
   logic             covered;

   // Cut off a region's front piece at its first inner cut; mark, clear or drop it.
   always_comb begin
      off_lo = req.seg.seq_lo - req.win_lo;
      off_hi = req.seg.seq_hi - req.win_lo;
      splits = (req.op == OP_DISCARD) || (req.op == OP_ENQUEUE) ||
               (req.op == OP_SET_SACKED);
      a_in = splits && (off_lo < req.off_a) && (req.off_a < off_hi);
      b_in = splits && (off_lo < req.off_b) && (req.off_b < off_hi);
      rsp.piece = req.seg;
      rsp.keep = 1'b1;
      rsp.done = 1'b0;
      if (a_in) begin
         rsp.piece.seq_hi = req.cut_a;
         off_end = req.off_a;
      end else if (b_in) begin
         rsp.piece.seq_hi = req.cut_b;
         off_end = req.off_b;
      end else begin
         rsp.done = 1'b1;
         off_end = off_hi;
      end
      covered = (off_lo >= req.off_a) && (off_end <= req.off_b);
      case (req.op)
         OP_DISCARD: begin
            rsp.keep = off_end > req.off_a;
         end
         OP_ENQUEUE: begin
            if (covered) begin
               rsp.piece.resent = 1'b1;
            end
         end
         OP_SET_SACKED: begin
            if (covered) begin
               rsp.piece.sacked = 1'b1;
            end
         end
         OP_CLR_SACKED: begin
            rsp.piece.sacked = 1'b0;
         end
         OP_CLR_RESENT: begin
            rsp.piece.resent = 1'b0;
         end
         default: begin
         end
      endcase
   end

endmodule

>>> rtl/core/sacksb_seq.sv
module sacksb_seq (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [3:0]                           req_opcode,
   input  logic [sacksb_pkg::SEQ_W-1:0]         req_from_seq,
   input  logic [sacksb_pkg::SEQ_W-1:0]         req_to_seq,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic [sacksb_pkg::SEQ_W-1:0]         rsp_value,
   output logic                                 rsp_block_sacked,
   output logic                                 rsp_block_rexmitted,
   output logic [sacksb_pkg::LIMIT_W-1:0]       rsp_sack_count,
   input  logic                                 csr_wr_en,
   input  logic [sacksb_pkg::LIMIT_W-1:0]       csr_wr_data,
   output sacksb_pkg::mem_req_type              mem_req,
   input  sacksb_pkg::region_type               rd_entry,
   output sacksb_pkg::cut_req_type              cut_req,
   input  sacksb_pkg::cut_rsp_type              cut_rsp
);
   import sacksb_pkg::*;

   // Control registers.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SEQ_W-1:0]   ws_ff, ws_in;
   logic [SEQ_W-1:0]   wstop_ff, wstop_in;
   logic               bank_ff, bank_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   // Per-command working registers.
   opcode_type         op_ff;
   logic [SEQ_W-1:0]   from_ff, to_ff;
   logic [SEQ_W-1:0]   cut_a_ff, cut_a_in, cut_b_ff, cut_b_in;
   logic [SEQ_W-1:0]   off_a_ff, off_a_in, off_b_ff, off_b_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   wr_idx_ff, wr_idx_in;
   region_type         seg_ff, seg_in;
   logic [SEQ_W-1:0]   acc_ff, acc_in;
   logic [LIMIT_W-1:0] sc_ff, sc_in;
   logic               prev_ff, prev_in;

   // Result registers.
   logic [1:0]         status_ff;
   logic [SEQ_W-1:0]   value_ff;
   logic               bs_ff, br_ff;
   logic [LIMIT_W-1:0] scnt_ff;

   // Finish request from the next-state logic.
   logic               fin;
   status_type         fin_status;
   logic [SEQ_W-1:0]   fin_value;
   logic               fin_bs, fin_br;
   logic [LIMIT_W-1:0] fin_sc;

   logic [SEQ_W-1:0]   off_f, off_t, off_stop, off_fe, from_eff;
   logic [SEQ_W-1:0]   off_lo, off_hi, base;
   logic               in_win, is_last, past_f, tail_need;
   logic [LIMIT_W-1:0] sc_next;

   assign busy = (state_ff != S_IDLE);

   // Splitter request.
   always_comb begin
      cut_req.op = op_ff;
      cut_req.seg = seg_ff;
      cut_req.win_lo = ws_ff;
      cut_req.cut_a = cut_a_ff;
      cut_req.cut_b = cut_b_ff;
      cut_req.off_a = off_a_ff;
      cut_req.off_b = off_b_ff;
   end

   // Next state, memory requests and results.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ws_in = ws_ff;
      wstop_in = wstop_ff;
      bank_in = bank_ff;
      cut_a_in = cut_a_ff;
      cut_b_in = cut_b_ff;
      off_a_in = off_a_ff;
      off_b_in = off_b_ff;
      idx_in = idx_ff;
      wr_idx_in = wr_idx_ff;
      seg_in = seg_ff;
      acc_in = acc_ff;
      sc_in = sc_ff;
      prev_in = prev_ff;
      fin = 1'b0;
      fin_status = ST_OK;
      fin_value = '0;
      fin_bs = 1'b0;
      fin_br = 1'b0;
      fin_sc = '0;
      mem_req.we = 1'b0;
      mem_req.wbank = ~bank_ff;
      mem_req.waddr = wr_idx_ff[IDX_W-1:0];
      mem_req.wdata = cut_rsp.piece;
      mem_req.rbank = bank_ff;
      mem_req.raddr = idx_ff;

      off_f = from_ff - ws_ff;
      off_t = to_ff - ws_ff;
      off_stop = wstop_ff - ws_ff;
      in_win = off_f <= off_stop;
      from_eff = off_f[SEQ_W-1] ? ws_ff : from_ff;
      off_fe = off_f[SEQ_W-1] ? '0 : off_f;
      off_lo = rd_entry.seq_lo - ws_ff;
      off_hi = rd_entry.seq_hi - ws_ff;
      past_f = off_hi > off_a_ff;
      base = (off_lo >= off_a_ff) ? rd_entry.seq_lo : from_ff;
      is_last = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
      sc_next = sc_ff + LIMIT_W'(rd_entry.sacked & ~prev_ff);
      tail_need = (op_ff == OP_ENQUEUE) && (off_b_ff > off_stop);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SETUP;
            end
         end

         // Range checks, cut points and the first read.
         S_SETUP: begin
            idx_in = '0;
            wr_idx_in = '0;
            mem_req.raddr = '0;
            acc_in = ((op_ff == OP_HI_SACKED) || (op_ff == OP_HI_RESENT)) ? ws_ff : '0;
            sc_in = '0;
            prev_in = 1'b0;
            cut_a_in = from_ff;
            cut_b_in = to_ff;
            off_a_in = off_f;
            off_b_in = off_t;
            state_in = S_PROC;
            case (op_ff)
               OP_INIT: begin
                  ws_in = from_ff;
                  wstop_in = from_ff;
                  count_in = '0;
                  fin = 1'b1;
               end
               OP_DISCARD: begin
                  cut_b_in = from_ff;
                  off_b_in = off_f;
                  if (!in_win) begin
                     fin = 1'b1;
                     fin_status = ST_RANGE;
                  end else if (count_ff == '0) begin
                     ws_in = from_ff;
                     fin = 1'b1;
                  end
               end
               OP_ENQUEUE: begin
                  if (!in_win || !(from_ff - to_ff >= 32'h8000_0000)) begin
                     fin = 1'b1;
                     fin_status = ST_RANGE;
                  end else if (count_ff == '0) begin
                     // First region of an empty table.
                     mem_req.we = 1'b1;
                     mem_req.wbank = bank_ff;
                     mem_req.waddr = '0;
                     mem_req.wdata = '{seq_lo: from_ff, seq_hi: to_ff,
                                       sacked: 1'b0, resent: 1'b0};
                     count_in = CNT_W'(1);
                     ws_in = from_ff;
                     wstop_in = to_ff;
                     fin = 1'b1;
                  end else if (from_ff == wstop_ff) begin
                     idx_in = IDX_W'(count_ff - CNT_W'(1));
                     mem_req.raddr = IDX_W'(count_ff - CNT_W'(1));
                     state_in = S_APPEND;
                  end
               end
               OP_SET_SACKED: begin
                  cut_a_in = from_eff;
                  off_a_in = off_fe;
                  if ((count_ff == '0) || (off_fe >= off_t) || (off_t > off_stop)) begin
                     fin = 1'b1;
                     fin_status = ST_RANGE;
                  end
               end
               OP_CHECK: begin
                  if ((count_ff == '0) || (off_f >= off_stop)) begin
                     fin = 1'b1;
                     fin_status = ST_RANGE;
                  end
               end
               OP_HI_SACKED, OP_HI_RESENT, OP_SACKED_TOTAL, OP_CLR_SACKED,
               OP_CLR_RESENT: begin
                  if (count_ff == '0) begin
                     fin = 1'b1;
                     fin_value = acc_in;
                  end
               end
               OP_RUN, OP_SACK_COUNT: begin
                  if (!in_win) begin
                     fin = 1'b1;
                     fin_status = ST_RANGE;
                  end else if ((count_ff == '0) || (from_ff == wstop_ff)) begin
                     fin = 1'b1;
                  end
               end
               OP_SACKED_FROM: begin
                  if (!in_win) begin
                     fin = 1'b1;
                     fin_status = ST_RANGE;
                  end else if (count_ff == '0) begin
                     fin = 1'b1;
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end

         // One table entry arrives from the active bank.
         S_PROC: begin
            seg_in = rd_entry;
            case (op_ff)
               OP_DISCARD, OP_ENQUEUE, OP_SET_SACKED, OP_CLR_SACKED, OP_CLR_RESENT: begin
                  state_in = S_EMIT;
               end
               OP_CHECK: begin
                  if (past_f || is_last) begin
                     fin = 1'b1;
                     fin_value = rd_entry.seq_hi - from_ff;
                     fin_bs = rd_entry.sacked;
                     fin_br = rd_entry.resent;
                  end
               end
               OP_HI_SACKED: begin
                  if (rd_entry.sacked) begin
                     acc_in = rd_entry.seq_hi;
                  end
               end
               OP_HI_RESENT: begin
                  if (rd_entry.resent) begin
                     acc_in = rd_entry.seq_hi;
                  end
               end
               OP_RUN: begin
                  if (past_f) begin
                     if (rd_entry.sacked || rd_entry.resent) begin
                        acc_in = acc_ff + (rd_entry.seq_hi - base);
                     end else begin
                        fin = 1'b1;
                        fin_value = acc_ff;
                     end
                  end
               end
               OP_SACKED_TOTAL: begin
                  if (rd_entry.sacked) begin
                     acc_in = acc_ff + (rd_entry.seq_hi - rd_entry.seq_lo);
                  end
               end
               OP_SACKED_FROM: begin
                  if (rd_entry.sacked && past_f) begin
                     acc_in = acc_ff + (rd_entry.seq_hi - base);
                  end
               end
               OP_SACK_COUNT: begin
                  if (past_f) begin
                     sc_in = sc_next;
                     prev_in = rd_entry.sacked;
                     if (sc_next >= limit_ff) begin
                        fin = 1'b1;
                        fin_value = SEQ_W'(sc_next);
                        fin_sc = sc_next;
                     end
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
            // Scans move on to the next entry, one per cycle.
            if ((state_in == S_PROC) && !fin) begin
               if (is_last) begin
                  fin = 1'b1;
                  fin_value = (op_ff == OP_SACK_COUNT) ? SEQ_W'(sc_in) : acc_in;
                  fin_sc = (op_ff == OP_SACK_COUNT) ? sc_in : '0;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
                  mem_req.raddr = idx_ff + IDX_W'(1);
               end
            end
         end

         // Pieces of one region go into the other bank, one per cycle.
         S_EMIT: begin
            if (cut_rsp.keep && (wr_idx_ff == CNT_W'(MAX_REGIONS))) begin
               fin = 1'b1;
               fin_status = ST_FULL;
            end else begin
               mem_req.we = cut_rsp.keep;
               if (cut_rsp.keep) begin
                  wr_idx_in = wr_idx_ff + CNT_W'(1);
               end
               if (!cut_rsp.done) begin
                  seg_in.seq_lo = cut_rsp.piece.seq_hi;
               end else if (is_last) begin
                  state_in = S_TAIL;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
                  mem_req.raddr = idx_ff + IDX_W'(1);
                  state_in = S_PROC;
               end
            end
         end

         // New data past the window, then the banks swap.
         S_TAIL: begin
            if (tail_need && (wr_idx_ff == CNT_W'(MAX_REGIONS))) begin
               fin = 1'b1;
               fin_status = ST_FULL;
            end else begin
               mem_req.we = tail_need;
               mem_req.wdata = '{seq_lo: wstop_ff, seq_hi: to_ff,
                                 sacked: 1'b0, resent: 1'b0};
               if (tail_need) begin
                  wstop_in = to_ff;
               end
               count_in = wr_idx_ff + CNT_W'(tail_need);
               bank_in = ~bank_ff;
               if (op_ff == OP_DISCARD) begin
                  ws_in = from_ff;
               end
               fin = 1'b1;
            end
         end

         // Append at the window end: extend the last region or add one.
         S_APPEND: begin
            mem_req.wbank = bank_ff;
            mem_req.wdata = '{seq_lo: from_ff, seq_hi: to_ff,
                              sacked: 1'b0, resent: 1'b0};
            if (!rd_entry.sacked && !rd_entry.resent && (rd_entry.seq_hi == from_ff)) begin
               mem_req.we = 1'b1;
               mem_req.waddr = idx_ff;
               mem_req.wdata = rd_entry;
               mem_req.wdata.seq_hi = to_ff;
               wstop_in = to_ff;
               fin = 1'b1;
            end else if (count_ff == CNT_W'(MAX_REGIONS)) begin
               fin = 1'b1;
               fin_status = ST_FULL;
            end else begin
               mem_req.we = 1'b1;
               mem_req.waddr = IDX_W'(count_ff);
               count_in = count_ff + CNT_W'(1);
               wstop_in = to_ff;
               fin = 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         state_in = S_IDLE;
      end
      rsp_valid_in = fin;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ws_ff <= '0;
         wstop_ff <= '0;
         bank_ff <= 1'b0;
         limit_ff <= SACK_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ws_ff <= ws_in;
         wstop_ff <= wstop_in;
         bank_ff <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         op_ff <= opcode_type'(req_opcode);
         from_ff <= req_from_seq;
         to_ff <= req_to_seq;
      end
      cut_a_ff <= cut_a_in;
      cut_b_ff <= cut_b_in;
      off_a_ff <= off_a_in;
      off_b_ff <= off_b_in;
      idx_ff <= idx_in;
      wr_idx_ff <= wr_idx_in;
      seg_ff <= seg_in;
      acc_ff <= acc_in;
      sc_ff <= sc_in;
      prev_ff <= prev_in;
      if (fin) begin
         status_ff <= fin_status;
         value_ff <= fin_value;
         bs_ff <= fin_bs;
         br_ff <= fin_br;
         scnt_ff <= fin_sc;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_value = value_ff;
   assign rsp_block_sacked = bs_ff;
   assign rsp_block_rexmitted = br_ff;
   assign rsp_sack_count = scnt_ff;

   // The rebuild never writes into the bank it is reading.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) && mem_req.we |-> mem_req.wbank != bank_ff)
      else $error("rebuild wrote into the active bank");

   // The table never holds more than its capacity.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_REGIONS))
      else $error("region count above capacity");

   // A result comes only from a command in flight and clears the busy flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_in |-> busy)
      else $error("result without a command in flight");

   // Each command gives a single result cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

   // An accepted command makes the block busy.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted command did not start");

endmodule

>>> rtl/core/sack_retransmit_scoreboard_core.sv
// SACK retransmission scoreboard.
// Holds up to MAX_REGIONS regions of sent sequence space in two table banks.
// Input words: drive req_opcode, req_from_seq and req_to_seq with start high;
// the word is taken at a clock edge where start is high and busy is low.
// Results: one word per command, shown for exactly one cycle with rsp_valid
// high. The receiver cannot stall, so it must take every strobe.
// Configuration: csr_wr_en with csr_wr_data writes the sack count limit
// (reset value 3); the user must write it only while the block is idle,
// as the block itself does not enforce this.
// Init, rejected commands and unused codes finish in the setup state.
// Queries scan the table at one entry a cycle.
// Commands that change the table rebuild it into the other bank, reading
// each region and writing its pieces in turn, then swap banks.
// Appends at the window end read the last region, then extend it or add one.
// Throughput: one command at a time; busy drops in the cycle the result is
// shown, so the next word can be taken at the edge that ends that cycle.
// Reset empties the table, clears the window to zero and needs no clearing
// pass; the block is ready in the cycle after reset falls.
module sack_retransmit_scoreboard_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [3:0]                     req_opcode,
   input  logic [sacksb_pkg::SEQ_W-1:0]   req_from_seq,
   input  logic [sacksb_pkg::SEQ_W-1:0]   req_to_seq,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic [sacksb_pkg::SEQ_W-1:0]   rsp_value,
   output logic                           rsp_block_sacked,
   output logic                           rsp_block_rexmitted,
   output logic [sacksb_pkg::LIMIT_W-1:0] rsp_sack_count,
   input  logic                           csr_wr_en,
   input  logic [sacksb_pkg::LIMIT_W-1:0] csr_wr_data
);
   import sacksb_pkg::*;

   mem_req_type mem_req;
   cut_req_type cut_req;
   cut_rsp_type cut_rsp;
   region_type  rd_entry;
   logic [ENTRY_W-1:0] rd_data0, rd_data1;

   // Sequencer.
   sacksb_seq u_seq (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_from_seq        (req_from_seq),
      .req_to_seq          (req_to_seq),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_value           (rsp_value),
      .rsp_block_sacked    (rsp_block_sacked),
      .rsp_block_rexmitted (rsp_block_rexmitted),
      .rsp_sack_count      (rsp_sack_count),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .mem_req             (mem_req),
      .rd_entry            (rd_entry),
      .cut_req             (cut_req),
      .cut_rsp             (cut_rsp)
   );

   // Region splitter.
   sacksb_cut u_cut (
      .req (cut_req),
      .rsp (cut_rsp)
   );

   // Two table banks; one is active while the other takes a rebuilt table.
   sacksb_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_REGIONS)) u_bank0 (
      .clock   (clock),
      .wr_en   (mem_req.we && !mem_req.wbank),
      .wr_addr (mem_req.waddr),
      .wr_data (mem_req.wdata),
      .rd_addr (mem_req.raddr),
      .rd_data (rd_data0)
   );

   sacksb_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_REGIONS)) u_bank1 (
      .clock   (clock),
      .wr_en   (mem_req.we && mem_req.wbank),
      .wr_addr (mem_req.waddr),
      .wr_data (mem_req.wdata),
      .rd_addr (mem_req.raddr),
      .rd_data (rd_data1)
   );

   // The active bank does not change between a read and its data.
   assign rd_entry = mem_req.rbank ? rd_data1 : rd_data0;

endmodule
